/* design/tlr_pkg.sv */
`timescale 1ns / 1ps

package tlr_pkg;

  localparam int unsigned LINE_CAPACITY = 64;

  // operation codes
  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  // event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_LINE   = 2'd1;
  localparam logic [1:0] EV_ESCAPE = 2'd2;

  // special key codes
  localparam logic [1:0] KEY_NONE = 2'd0;
  localparam logic [1:0] KEY_UP   = 2'd1;
  localparam logic [1:0] KEY_DOWN = 2'd2;

  // received characters with a meaning
  localparam logic [7:0] CH_CTRL_C    = 8'h03;
  localparam logic [7:0] CH_ESC       = 8'h1B;
  localparam logic [7:0] CH_BRACKET   = 8'h5B;
  localparam logic [7:0] CH_UP        = 8'h41;
  localparam logic [7:0] CH_DOWN      = 8'h42;
  localparam logic [7:0] CH_ENTER     = 8'h0D;
  localparam logic [7:0] CH_BACKSPACE = 8'h08;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [5:0] read_index;
  } item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [1:0] key_code;
    logic [6:0] line_length;
    logic [7:0] read_data;
    logic       line_pending;
  } result_t;

endpackage

/* design/terminal_line_receiver.sv */
`timescale 1ns / 1ps

// Terminal line receiver.
// Input channel (item_valid / item_stall / item) carries one operation per beat:
// a received byte, a release of the completed line, or a read of the line store.
// Output channel (result_valid / result_stall / result) returns exactly one
// status beat per input beat, in order.
// An accepted beat passes the read stage register, then the output register.
// The line store is a synchronous RAM read in the cycle of acceptance; its
// data is merged into the output register as the read stage advances.
// Throughput: one beat per cycle unless the output stalls. Line state lives
// in flops and is updated at the accepting edge, so the next byte sees it
// without delay; a write and a later read of the same entry never share an edge.
// Reset (rst, synchronous) empties the line, clears the escape recognizer and
// special key, and enables input; no clearing pass, ready right after reset.
// Store not cleared; user must read only written entries, the block won't check.
// When the receiver stalls, the result is held in the output register, one
// more beat waits in the read stage, and item_stall rises once both are full.
module terminal_line_receiver #(
  parameter int unsigned LINE_CAPACITY = tlr_pkg::LINE_CAPACITY
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  tlr_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output tlr_pkg::result_t result
);

  localparam int unsigned AW = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
  localparam int unsigned CW = $clog2(LINE_CAPACITY + 1);

  typedef enum logic [1:0] {
    ESC_IDLE         = 2'd0,
    ESC_WAIT_BRACKET = 2'd2,
    ESC_WAIT_KEY     = 2'd3
  } esc_t;

  // line state
  logic [CW-1:0] fill_count, fill_count_next;
  logic          accepting, accepting_next;
  esc_t          escape_stage, escape_stage_next;
  logic [1:0]    special_key, special_key_next;

  logic [7:0] line_store [LINE_CAPACITY];
  logic [7:0] store_q;

  // read stage
  logic             s1_valid;
  tlr_pkg::result_t s1_status;
  logic             s1_read;
  tlr_pkg::result_t result_next;

  logic          in_accept;
  logic          s1_advance;
  logic          store_we;
  logic [1:0]    ev;
  logic          read_hit;
  logic [AW-1:0] read_addr;

  assign s1_advance = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !s1_advance;
  assign in_accept  = item_valid && !item_stall;

  assign read_addr = AW'(item.read_index);
  assign read_hit  = (item.operation == tlr_pkg::OP_READ) &&
                     (32'(item.read_index) < LINE_CAPACITY);

  always_comb begin
    fill_count_next   = fill_count;
    accepting_next    = accepting;
    escape_stage_next = escape_stage;
    special_key_next  = special_key;
    store_we          = 1'b0;
    ev                = tlr_pkg::EV_NONE;
    case (item.operation)
      tlr_pkg::OP_BYTE: begin
        if (accepting) begin
          if (item.rx_byte == tlr_pkg::CH_CTRL_C) begin
            fill_count_next = '0;
          end else if (item.rx_byte == tlr_pkg::CH_ESC) begin
            escape_stage_next = ESC_WAIT_BRACKET;
          end else if (escape_stage != ESC_IDLE) begin
            case (escape_stage)
              ESC_WAIT_BRACKET: begin
                escape_stage_next = (item.rx_byte == tlr_pkg::CH_BRACKET) ?
                                    ESC_WAIT_KEY : ESC_IDLE;
              end
              ESC_WAIT_KEY: begin
                if (item.rx_byte == tlr_pkg::CH_UP) begin
                  special_key_next = tlr_pkg::KEY_UP;
                end else if (item.rx_byte == tlr_pkg::CH_DOWN) begin
                  special_key_next = tlr_pkg::KEY_DOWN;
                end
                escape_stage_next = ESC_IDLE;
                ev                = tlr_pkg::EV_ESCAPE;
              end
              default: begin
                escape_stage_next = ESC_WAIT_BRACKET;
              end
            endcase
          end else if (item.rx_byte == tlr_pkg::CH_BACKSPACE) begin
            if (fill_count != '0) begin
              fill_count_next = fill_count - CW'(1);
            end
          end else begin
            if (fill_count < CW'(LINE_CAPACITY)) begin
              store_we        = 1'b1;
              fill_count_next = fill_count + CW'(1);
            end
            if (item.rx_byte == tlr_pkg::CH_ENTER) begin
              accepting_next = 1'b0;
              ev             = tlr_pkg::EV_LINE;
            end
          end
        end
      end
      tlr_pkg::OP_RELEASE: begin
        fill_count_next = '0;
        accepting_next  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // status from the read stage with the store data merged in
  always_comb begin
    result_next           = s1_status;
    result_next.read_data = s1_read ? store_q : 8'd0;
  end

  // line store: one write port at the fill position, one registered read port
  always_ff @(posedge clk) begin
    if (in_accept && store_we) begin
      line_store[fill_count[AW-1:0]] <= item.rx_byte;
    end
    if (in_accept && read_hit) begin
      store_q <= line_store[read_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      accepting    <= 1'b1;
      escape_stage <= ESC_IDLE;
      special_key  <= tlr_pkg::KEY_NONE;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (in_accept) begin
        fill_count   <= fill_count_next;
        accepting    <= accepting_next;
        escape_stage <= escape_stage_next;
        special_key  <= special_key_next;
      end
      if (in_accept) begin
        s1_valid <= 1'b1;
      end else if (s1_advance) begin
        s1_valid <= 1'b0;
      end
      if (s1_advance) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_status.event_res    <= ev;
      s1_status.key_code     <= special_key_next;
      s1_status.line_length  <= 7'(fill_count_next);
      s1_status.read_data    <= '0;
      s1_status.line_pending <= !accepting_next;
      s1_read                <= read_hit;
    end
    if (s1_advance) begin
      result <= result_next;
    end
  end

endmodule
